/* src/lane_steering_speed_law_core_macros.svh */
// assertion macros shared by the lane steering checker
// depends on nothing; taken in by `include in the files that assert
`ifndef LANE_STEERING_SPEED_LAW_CORE_MACROS_SVH
`define LANE_STEERING_SPEED_LAW_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define LSSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define LSSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lssl_pkg.sv */
// shared types, constants and the arctangent table of the lane steering core
// depends on nothing
`default_nettype none

package lssl_pkg;

	// cordic datapath widths and step count
	localparam int CW         = 42;
	localparam int ZW         = 23;
	localparam int CNTW       = 5;
	localparam int STEPS      = 20;
	localparam int FRAC_SHIFT = 20;

	// speed and steering law constants
	localparam int NEAR_LIMIT  = 9830;
	localparam int PI_UNITS    = 3294199;
	localparam int STEER_SCALE = 1800;
	localparam int STEER_MAX   = 200;
	localparam int TRIM_FORCE  = -10;
	localparam int TRIM_STEP   = 2;

	// steering quotient width and its reciprocal, floor(1800 * 2^20 / pi units)
	localparam int DIV_BITS    = 8;
	localparam int STEER_RECIP = 572;
	localparam int RECIP_SHIFT = 20;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_SPEED   = 2'd0;
	localparam logic [1:0] REG_ROAD_REF     = 2'd1;
	localparam logic [1:0] REG_HEIGHT_RATIO = 2'd2;
	localparam logic [1:0] REG_DRIVER_FAULT = 2'd3;

	localparam logic [15:0] HEIGHT_RATIO_RST = 16'd3072;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic load_road;
		logic load_car;
		logic step;
		logic store_road;
		logic store_car;
		logic trim;
		logic prep;
		logic div_step;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic iter_last;
		logic fault;
	} sts_t;

	// atan(2^-i) in units of 2^-20 rad, rounded to nearest
	function automatic logic [ZW-1:0] atan_lut(input logic [CNTW-1:0] idx);
		logic [ZW-1:0] v;
		unique case (idx)
			5'd0:  v = 23'd823550;
			5'd1:  v = 23'd486170;
			5'd2:  v = 23'd256879;
			5'd3:  v = 23'd130396;
			5'd4:  v = 23'd65451;
			5'd5:  v = 23'd32757;
			5'd6:  v = 23'd16383;
			5'd7:  v = 23'd8192;
			5'd8:  v = 23'd4096;
			5'd9:  v = 23'd2048;
			5'd10: v = 23'd1024;
			5'd11: v = 23'd512;
			5'd12: v = 23'd256;
			5'd13: v = 23'd128;
			5'd14: v = 23'd64;
			5'd15: v = 23'd32;
			5'd16: v = 23'd16;
			5'd17: v = 23'd8;
			5'd18: v = 23'd4;
			5'd19: v = 23'd2;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* src/lssl_ctrl.sv */
// controller state machine of the lane steering core
// depends on lssl_pkg; drives lssl_dp through cmd_t and reads sts_t
`default_nettype none

module lssl_ctrl import lssl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD_ROAD,
		S_ITER_ROAD,
		S_LOAD_CAR,
		S_ITER_CAR,
		S_TRIM,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit_ok   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// commands decoded from the state and the channel handshakes
	always_comb begin
		cmd            = '0;
		cmd.capture    = in_ready && in_valid;
		cmd.load_road  = (state_q == S_LOAD_ROAD);
		cmd.step       = (state_q == S_ITER_ROAD) || (state_q == S_ITER_CAR);
		cmd.load_car   = (state_q == S_LOAD_CAR);
		cmd.store_road = (state_q == S_LOAD_CAR);
		cmd.store_car  = (state_q == S_TRIM);
		cmd.trim       = (state_q == S_TRIM);
		cmd.prep       = (state_q == S_PREP);
		cmd.div_step   = (state_q == S_DIV);
		cmd.emit       = emit_ok;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= sts.fault ? S_DONE : S_LOAD_ROAD;
					end
				end
				S_LOAD_ROAD: state_q <= S_ITER_ROAD;
				S_ITER_ROAD: begin
					if (sts.iter_last) begin
						state_q <= S_LOAD_CAR;
					end
				end
				S_LOAD_CAR: state_q <= S_ITER_CAR;
				S_ITER_CAR: begin
					if (sts.iter_last) begin
						state_q <= S_TRIM;
					end
				end
				S_TRIM: state_q <= S_PREP;
				S_PREP: state_q <= S_DIV;
				// single correction step of the steering quotient
				S_DIV: state_q <= S_DONE;
				S_DONE: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/lssl_dp.sv */
// datapath of the lane steering core: config registers, shared cordic,
// speed trim, steering quotient and result register; depends on lssl_pkg
`default_nettype none

module lssl_dp import lssl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] bottom_offset,
	input  logic signed [15:0] right_offset,
	input  logic signed [15:0] top_offset,
	input  logic signed [15:0] left_offset,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               status,
	output logic signed [9:0]  speed_command,
	output logic signed [8:0]  steering_command
);

	// configuration and trim state
	logic [7:0]         base_speed_q;
	logic signed [15:0] road_ref_q;
	logic [15:0]        height_ratio_q;
	logic               driver_fault_q;
	logic signed [7:0]  trim_q;

	// captured frame
	logic signed [16:0] near_q;
	logic signed [16:0] far_q;
	logic               fault_q;

	// cordic unit
	logic signed [CW-1:0] cx_q;
	logic signed [CW-1:0] cy_q;
	logic signed [ZW-1:0] cz_q;
	logic                 zero_q;
	logic [CNTW-1:0]      cnt_q;
	logic signed [ZW-1:0] road_q;
	logic signed [ZW-1:0] car_q;

	// steering quotient
	logic [31:0]         rem_q;
	logic [DIV_BITS-1:0] quo_q;
	logic                big_q;
	logic                neg_q;

	// result register
	logic               status_q;
	logic signed [9:0]  speed_q;
	logic signed [8:0]  steer_q;

	logic signed [17:0]   road_y;
	logic signed [CW-1:0] road_y0;
	logic signed [CW-1:0] car_y0;
	logic signed [CW-1:0] x0;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] lut;
	logic signed [7:0]    trim_next;
	logic [20:0]          car_mag;
	logic [24:0]          car_mag9;
	logic [DIV_BITS-1:0]  quo_est;
	logic [31:0]          fix_prod;
	logic [8:0]           steer_mag;

	assign sts.iter_last = (cnt_q == CNTW'(STEPS - 1));
	assign sts.fault     = driver_fault_q;

	assign status           = status_q;
	assign speed_command    = speed_q;
	assign steering_command = steer_q;

	// cordic start vectors, scaled by 2^20
	assign road_y  = {far_q[16], far_q} - {near_q[16], near_q};
	assign road_y0 = {{(CW - 38){road_y[17]}}, road_y, {FRAC_SHIFT{1'b0}}};
	assign car_y0  = {{(CW - 37){far_q[16]}}, far_q, {FRAC_SHIFT{1'b0}}};
	assign x0      = {{(CW - 37){1'b0}}, height_ratio_q, 1'b0, {FRAC_SHIFT{1'b0}}};

	// one vectoring step: floor shifts and table angle
	assign xs  = cx_q >>> cnt_q;
	assign ys  = cy_q >>> cnt_q;
	assign lut = atan_lut(cnt_q);

	// speed trim rule on the road angle and the near midpoint
	always_comb begin
		logic signed [16:0] ref17;
		logic [16:0]        ref_mag;
		logic [23:0]        ref_scaled;
		logic [22:0]        road_mag;
		logic signed [9:0]  t10;
		logic signed [17:0] near18;
		logic [17:0]        near_mag;
		ref17      = {road_ref_q[15], road_ref_q};
		ref_mag    = ref17[16] ? 17'(-ref17) : 17'(ref17);
		ref_scaled = {ref_mag, 7'b0};
		road_mag   = road_q[ZW-1] ? 23'(-road_q) : 23'(road_q);
		if ({1'b0, road_mag} < ref_scaled) begin
			t10 = {{2{trim_q[7]}}, trim_q} + 10'sd2;
		end else begin
			t10 = {{2{trim_q[7]}}, trim_q} - 10'(TRIM_STEP);
		end
		priority if (t10 > 10'sd127) begin
			trim_next = 8'sd127;
		end else if (t10 < -10'sd128) begin
			trim_next = -8'sd128;
		end else begin
			trim_next = t10[7:0];
		end
		near18   = {near_q[16], near_q};
		near_mag = near18[17] ? 18'(-near18) : 18'(near18);
		if (near_mag > 18'(NEAR_LIMIT)) begin
			trim_next = 8'(TRIM_FORCE);
		end
	end

	// car angle magnitude and the twenty degree limit
	assign car_mag  = car_q[ZW-1] ? 21'(-car_q) : 21'(car_q);
	assign car_mag9 = {car_mag, 3'b0} + 25'(car_mag);

	// steering quotient: reciprocal estimate is exact or one low, one compare fixes it
	assign quo_est   = DIV_BITS'((32'(car_mag) * 32'(STEER_RECIP)) >> RECIP_SHIFT);
	assign fix_prod  = 32'({1'b0, quo_q} + 9'd1) * 32'(PI_UNITS);
	assign steer_mag = big_q ? 9'(STEER_MAX) : {1'b0, quo_q};

	// configuration registers and speed trim
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q   <= '0;
			road_ref_q     <= '0;
			height_ratio_q <= HEIGHT_RATIO_RST;
			driver_fault_q <= 1'b0;
			trim_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_BASE_SPEED:   base_speed_q   <= cfg_data[7:0];
					REG_ROAD_REF:     road_ref_q     <= cfg_data;
					REG_HEIGHT_RATIO: height_ratio_q <= cfg_data;
					REG_DRIVER_FAULT: driver_fault_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.trim) begin
				trim_q <= trim_next;
			end
		end
	end

	// frame capture, cordic, steering quotient and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			near_q  <= {bottom_offset[15], bottom_offset} + {right_offset[15], right_offset};
			far_q   <= {top_offset[15], top_offset} + {left_offset[15], left_offset};
			fault_q <= driver_fault_q;
		end
		if (cmd.load_road || cmd.load_car) begin
			cx_q   <= x0;
			cy_q   <= cmd.load_road ? road_y0 : car_y0;
			cz_q   <= '0;
			zero_q <= cmd.load_road ? (road_y == 18'sd0) : (far_q == 17'sd0);
			cnt_q  <= '0;
		end else if (cmd.step) begin
			if (cy_q[CW-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - lut;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + lut;
			end
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.store_road) begin
			road_q <= zero_q ? '0 : cz_q;
		end
		if (cmd.store_car) begin
			car_q <= zero_q ? '0 : cz_q;
		end
		if (cmd.prep) begin
			rem_q <= 32'(car_mag) * 32'(STEER_SCALE);
			quo_q <= quo_est;
			big_q <= (car_mag9 > 25'(PI_UNITS));
			neg_q <= car_q[ZW-1];
		end else if (cmd.div_step) begin
			if (rem_q >= fix_prod) begin
				quo_q <= quo_q + 1'b1;
			end
		end
		if (cmd.emit) begin
			if (fault_q) begin
				status_q <= 1'b1;
				speed_q  <= '0;
				steer_q  <= '0;
			end else begin
				status_q <= 1'b0;
				speed_q  <= {2'b00, base_speed_q} + {{2{trim_q[7]}}, trim_q};
				steer_q  <= neg_q ? 9'(-steer_mag) : steer_mag;
			end
		end
	end

endmodule

`default_nettype wire

/* src/lane_steering_speed_law_core.sv */
// Lane steering and speed law core, top level.
// Input channel: in_valid/in_ready carry one frame of four lane-edge offsets
// (signed Q2.14). Output channel: out_valid/out_ready carry status,
// speed_command and steering_command for that frame, one result per frame.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes base_speed,
// road_angle_ref, height_ratio or driver_fault; the user must write only
// while idle, the block itself does not enforce it. The block takes one
// frame at a time: two 20-step runs of the shared cordic unit (road angle,
// then car angle), a trim step and a reciprocal multiply with one
// correction for the steering quotient; under driver_fault a frame goes
// straight to its result.
// A finished result waits in the output register; in_ready returns as soon
// as the result is loaded, so the next frame can be taken while the
// receiver stalls. A second result is held back until the first is taken.
// Reset: arst_n clears the controller, empties the output and returns the
// configuration registers to their reset values (height_ratio 3072) and the trim to zero.
// Depends on lssl_pkg, lssl_ctrl and lssl_dp.
`default_nettype none

module lane_steering_speed_law_core import lssl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] bottom_offset,
	input  logic signed [15:0] right_offset,
	input  logic signed [15:0] top_offset,
	input  logic signed [15:0] left_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [9:0]  speed_command,
	output logic signed [8:0]  steering_command
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	lssl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and state
	lssl_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.bottom_offset    (bottom_offset),
		.right_offset     (right_offset),
		.top_offset       (top_offset),
		.left_offset      (left_offset),
		.cmd              (cmd),
		.sts              (sts),
		.status           (status),
		.speed_command    (speed_command),
		.steering_command (steering_command)
	);

endmodule

`default_nettype wire

/* src/lssl_checker.sv */
// port-level checker of the lane steering core and its bind
// depends on lane_steering_speed_law_core_macros.svh and the top level
`default_nettype none
`include "lane_steering_speed_law_core_macros.svh"

module lssl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input logic [1:0]         cfg_index,
	input logic [15:0]        cfg_data,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [15:0] bottom_offset,
	input logic signed [15:0] right_offset,
	input logic signed [15:0] top_offset,
	input logic signed [15:0] left_offset,
	input logic               out_valid,
	input logic               out_ready,
	input logic               status,
	input logic signed [9:0]  speed_command,
	input logic signed [8:0]  steering_command
);

	// a stalled result holds
	`LSSL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(speed_command) && $stable(steering_command) && $stable(status), "stalled result changed")

	// one frame at a time: busy right after an input transaction
	`LSSL_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while busy")

	// a fault result carries zero commands
	`LSSL_ASSERT_NOW(a_fault_zero, clk, arst_n, out_valid && status, speed_command == 10'sd0 && steering_command == 9'sd0, "fault result not zero")

	// steering stays within the clamp
	`LSSL_ASSERT_NOW(a_steer_range, clk, arst_n, out_valid, steering_command <= 9'sd200 && steering_command >= -9'sd200, "steering out of range")

endmodule

bind lane_steering_speed_law_core lssl_checker u_lssl_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for lane_steering_speed_law_core: directed and random frames,
// with a predictor of the angle, trim and steering laws
// depends on lssl_pkg and the lane_steering_speed_law_core rtl
module testbench;
	import lssl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 64;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_FRAMES   = 200;

	// atan(2^-i) in units of 2^-20 rad
	localparam longint ATAN_UNITS [20] = '{
		823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
	};

	typedef struct {
		logic signed [15:0] bottom;
		logic signed [15:0] right;
		logic signed [15:0] top;
		logic signed [15:0] left;
	} frame_t;

	typedef struct {
		logic              status;
		logic signed [9:0] speed;
		logic signed [8:0] steering;
	} command_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] bottom_offset;
	logic signed [15:0] right_offset;
	logic signed [15:0] top_offset;
	logic signed [15:0] left_offset;
	logic               out_valid;
	logic               out_ready;
	logic               status;
	logic signed [9:0]  speed_command;
	logic signed [8:0]  steering_command;

	// shadow registers and trim state of the predictor
	logic [7:0]         base_speed_cfg;
	logic [15:0]        road_ref_cfg;
	logic [15:0]        ratio_cfg;
	logic               fault_cfg;
	logic signed [7:0]  trim_state;

	command_t expected_commands[$];

	int frames_sent;
	int fault_frames;
	int results_checked;
	int mismatches;
	int idle_cycles;
	int burst_left;
	bit long_hold_req;

	lane_steering_speed_law_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.bottom_offset    (bottom_offset),
		.right_offset     (right_offset),
		.top_offset       (top_offset),
		.left_offset      (left_offset),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.speed_command    (speed_command),
		.steering_command (steering_command)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// vectoring cordic, atan2(y, x) for x >= 0 in units of 2^-20 rad
	function automatic longint cordic_angle(input longint y_in, input longint x_in);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		int i;
		if (y_in == 0)
			return 0;
		x = x_in <<< FRAC_SHIFT;
		y = y_in <<< FRAC_SHIFT;
		z = 0;
		for (i = 0; i < 20; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_UNITS[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_UNITS[i];
			end
		end
		return z;
	endfunction

	// commands for one frame; advances the trim state unless driver fault is set
	function automatic command_t predict_commands(input frame_t f);
		command_t c;
		longint near_sum;
		longint far_sum;
		longint x;
		longint road;
		longint car;
		longint ref_mag;
		longint mag;
		longint steer;
		int trim;
		int speed;
		if (fault_cfg) begin
			c.status = 1'b1;
			c.speed = '0;
			c.steering = '0;
			return c;
		end
		near_sum = f.bottom;
		near_sum = near_sum + f.right;
		far_sum = f.top;
		far_sum = far_sum + f.left;
		x = ratio_cfg;
		x = 2 * x;
		road = cordic_angle(far_sum - near_sum, x);
		car = cordic_angle(far_sum, x);

		// speed trim law
		ref_mag = $signed(road_ref_cfg);
		if (ref_mag < 0)
			ref_mag = -ref_mag;
		ref_mag = ref_mag * 128;
		trim = trim_state;
		if ((road < 0 ? -road : road) < ref_mag)
			trim = trim + TRIM_STEP;
		else
			trim = trim - TRIM_STEP;
		if (trim > 127)
			trim = 127;
		if (trim < -128)
			trim = -128;
		if ((near_sum < 0 ? -near_sum : near_sum) > NEAR_LIMIT)
			trim = TRIM_FORCE;
		trim_state = trim[7:0];

		// steering law, truncated toward zero and clamped past 20 degrees
		mag = (car < 0) ? -car : car;
		if (mag * 9 <= PI_UNITS)
			steer = (mag * STEER_SCALE) / PI_UNITS;
		else
			steer = STEER_MAX;
		if (car < 0)
			steer = -steer;

		speed = base_speed_cfg;
		speed = speed + trim;
		c.status = 1'b0;
		c.speed = speed[9:0];
		c.steering = steer[8:0];
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_checked, what, got, want);
		mismatches++;
	endtask

	// register write, shadowed for the predictor
	task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		case (index)
			REG_BASE_SPEED:   base_speed_cfg = data[7:0];
			REG_ROAD_REF:     road_ref_cfg = data;
			REG_HEIGHT_RATIO: ratio_cfg = data;
			REG_DRIVER_FAULT: fault_cfg = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] base, input logic [15:0] road_ref,
		input logic [15:0] ratio, input logic fault);
		write_reg(REG_BASE_SPEED, {8'd0, base});
		write_reg(REG_ROAD_REF, road_ref);
		write_reg(REG_HEIGHT_RATIO, ratio);
		write_reg(REG_DRIVER_FAULT, {15'd0, fault});
	endtask

	// offer one frame, predict at the transaction, then maybe idle
	task automatic send_frame(input frame_t f);
		@(negedge clk);
		in_valid      <= 1'b1;
		bottom_offset <= f.bottom;
		right_offset  <= f.right;
		top_offset    <= f.top;
		left_offset   <= f.left;
		do
			@(posedge clk);
		while (!in_ready);
		if (fault_cfg)
			fault_frames++;
		expected_commands.push_back(predict_commands(f));
		frames_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(0, 70)) @(negedge clk);
			else
				repeat ($urandom_range(0, 3)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
		end
	endtask

	task automatic send_offsets(input int b, input int r, input int t, input int l);
		frame_t f;
		f.bottom = b[15:0];
		f.right  = r[15:0];
		f.top    = t[15:0];
		f.left   = l[15:0];
		send_frame(f);
	endtask

	// drop valid, wait for every result, then let the core go idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_commands.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] random_offset();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = 16'($urandom_range(0, 8191) - 4096);
			4, 5, 6:    v = 16'($urandom);
			7: begin
				case ($urandom_range(0, 4))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					3: v = 16'hffff;
					default: v = 16'h0001;
				endcase
			end
			default:    v = 16'($urandom_range(0, 32767) - 16384);
		endcase
		return v;
	endfunction

	task automatic send_random_frame();
		frame_t f;
		f.bottom = random_offset();
		f.right  = random_offset();
		f.top    = random_offset();
		f.left   = random_offset();
		send_frame(f);
	endtask

	// offset extremes and alternating bit patterns
	task automatic test_field_extremes();
		configure(8'd255, 16'd1000, HEIGHT_RATIO_RST, 1'b0);
		send_offsets(0, 0, 0, 0);
		send_offsets(32767, 32767, 32767, 32767);
		send_offsets(-32768, -32768, -32768, -32768);
		send_offsets(32767, -32768, -32768, 32767);
		send_offsets(21845, -21846, 21845, -21846);
		settle();
	endtask

	// near midpoint on both sides of 0.3
	task automatic test_near_limit();
		configure(8'd0, 16'd25736, HEIGHT_RATIO_RST, 1'b0);
		send_offsets(4915, 4915, 0, 0);
		send_offsets(4915, 4916, 0, 0);
		send_offsets(-4915, -4915, 0, 0);
		send_offsets(-4915, -4916, 0, 0);
		send_offsets(9830, 0, 100, 100);
		settle();
	endtask

	// car angle on both sides of 20 degrees, and tiny angles
	task automatic test_steering_clamp();
		configure(8'd128, 16'd0, HEIGHT_RATIO_RST, 1'b0);
		send_offsets(0, 0, 1118, 1118);
		send_offsets(0, 0, 1118, 1119);
		send_offsets(0, 0, -1118, -1118);
		send_offsets(0, 0, -1118, -1119);
		send_offsets(0, 0, 1, 0);
		send_offsets(0, 0, 0, -1);
		settle();
	endtask

	// driver fault, zero and full height ratio, most negative reference
	task automatic test_special_cases();
		configure(8'd77, 16'd4000, HEIGHT_RATIO_RST, 1'b1);
		send_offsets(1000, -2000, 3000, 4000);
		send_offsets(-32768, 32767, 0, 0);
		settle();
		configure(8'd77, 16'd4000, 16'd0, 1'b0);
		send_offsets(0, 0, 5000, 5000);
		send_offsets(100, 100, -5000, -5000);
		send_offsets(0, 0, 0, 0);
		settle();
		configure(8'd200, 16'h8000, 16'hffff, 1'b0);
		send_offsets(-1, 1, 32767, 32767);
		settle();
		write_reg(REG_HEIGHT_RATIO, HEIGHT_RATIO_RST);
		send_offsets(200, 300, -400, 500);
		send_offsets(-20000, 20000, 30000, 30000);
		settle();
	endtask

	// phases of random frames, each under its own register setting
	task automatic test_random_phases();
		int p;
		int n;
		logic [7:0] base;
		logic [15:0] road_ref;
		logic [15:0] ratio;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       base = 8'd0;
				1:       base = 8'd255;
				default: base = 8'($urandom_range(0, 255));
			endcase
			case (p % 5)
				0:       road_ref = 16'd0;
				1:       road_ref = 16'd25736;
				2:       road_ref = -16'sd25736;
				3:       road_ref = 16'h8000;
				default: road_ref = 16'($urandom_range(0, 51472) - 25736);
			endcase
			case (p)
				2:       ratio = 16'd1;
				3:       ratio = 16'hffff;
				4:       ratio = HEIGHT_RATIO_RST;
				6:       ratio = 16'd0;
				default: ratio = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1024, 8192))
					: 16'($urandom_range(1, 65535));
			endcase
			configure(base, road_ref, ratio, p == 7);
			for (n = 0; n < PHASE_FRAMES; n++)
				send_random_frame();
			settle();
		end
	endtask

	// receiver holds off long enough for the core to stall its input
	task automatic test_backpressure();
		int n;
		configure(8'd60, 16'd3000, HEIGHT_RATIO_RST, 1'b0);
		long_hold_req = 1'b1;
		for (n = 0; n < 20; n++)
			send_random_frame();
		settle();
	endtask

	// receiver: stretches of random stall patterns, plus the requested long hold
	initial begin
		int hold_left;
		int stretch_left;
		int mode;
		int period;
		int tick;
		hold_left = 0;
		stretch_left = 0;
		mode = 0;
		period = 1;
		tick = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode = $urandom_range(0, 3);
					stretch_left = $urandom_range(10, 200);
					period = $urandom_range(2, 16);
					tick = 0;
				end
				stretch_left--;
				tick++;
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 3) != 0);
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (tick % period == 0);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		command_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_commands.size() == 0) begin
				report_mismatch("unexpected transaction, speed", int'(speed_command), 0);
			end else begin
				want = expected_commands.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (speed_command !== want.speed)
					report_mismatch("speed_command", int'(speed_command), int'(want.speed));
				if (steering_command !== want.steering)
					report_mismatch("steering_command", int'(steering_command),
						int'(want.steering));
			end
			results_checked++;
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("lane_steering_speed_law_core regression: fail");
			$finish;
		end
	end

	// test sequence
	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_BASE_SPEED;
		cfg_data      = '0;
		in_valid      = 1'b0;
		bottom_offset = '0;
		right_offset  = '0;
		top_offset    = '0;
		left_offset   = '0;
		base_speed_cfg = '0;
		road_ref_cfg  = '0;
		ratio_cfg     = HEIGHT_RATIO_RST;
		fault_cfg     = 1'b0;
		trim_state    = '0;
		frames_sent   = 0;
		fault_frames  = 0;
		results_checked = 0;
		mismatches    = 0;
		burst_left    = 1;
		long_hold_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_near_limit();
		test_steering_clamp();
		test_special_cases();
		test_random_phases();
		test_backpressure();

		if (expected_commands.size() != 0)
			report_mismatch("results never delivered", 0, expected_commands.size());
		$display("covered %0d frames (%0d under driver fault) over %0d register settings",
			frames_sent, fault_frames, RANDOM_PHASES + 8);
		$display("checked %0d results with %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("lane_steering_speed_law_core regression: pass");
		else
			$display("lane_steering_speed_law_core regression: fail");
		$finish;
	end

endmodule
